// ----- rtl/sawc_pkg.sv -----
`timescale 1ns / 1ps

package sawc_pkg;

  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int LAT_W     = 8;
  localparam int RESULT_W  = 9;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Access opcodes.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE  = 2'd3;

  // Configuration reset values.
  localparam logic             RST_ENABLE = 1'b1;
  localparam logic [LAT_W-1:0] RST_LOOKUP = 8'd0;
  localparam logic [LAT_W-1:0] RST_READ   = 8'd30;
  localparam logic [LAT_W-1:0] RST_WRITE  = 8'd10;

  typedef struct packed {
    logic             enable;
    logic [LAT_W-1:0] lookup_lat;
    logic [LAT_W-1:0] read_lat;
    logic [LAT_W-1:0] write_lat;
  } sawc_cfg_t;

  typedef struct packed {
    logic clear;    // write a zero row at the clear pointer
    logic capture;  // take the request and read its set
    logic commit;   // update the set, counters and response register
  } sawc_cmd_t;

  typedef struct packed {
    logic clear_done;
  } sawc_status_t;

endpackage

// ----- rtl/sawc_ctrl.sv -----
`timescale 1ns / 1ps

module sawc_ctrl import sawc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output sawc_cmd_t    cmd,
  input  sawc_status_t status
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

  state_t state;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR:  cmd.clear   = 1'b1;
      ST_IDLE:   cmd.capture = req_valid;
      // The lookup waits while the previous response has not been taken.
      ST_LOOKUP: cmd.commit  = !rsp_valid || rsp_ready;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR:  if (status.clear_done) state <= ST_IDLE;
        ST_IDLE:   if (cmd.capture) state <= ST_LOOKUP;
        ST_LOOKUP: if (cmd.commit) state <= ST_IDLE;
        default:   state <= ST_CLEAR;
      endcase
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !req_ready)
    else $error("request accepted during the clearing pass");

  a_rsp_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_LOOKUP)
    else $error("response raised outside a lookup");

endmodule

// ----- rtl/sawc_datapath.sv -----
`timescale 1ns / 1ps

module sawc_datapath import sawc_pkg::*; #(
  parameter int NUM_SETS    = 8,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  sawc_cmd_t           cmd,
  output sawc_status_t        status,
  input  sawc_cfg_t           cfg,
  input  logic [OP_W-1:0]     opcode,
  input  logic [ADDR_W-1:0]   address,
  output logic [RESULT_W-1:0] latency,
  output logic                hit,
  output logic                victim_written,
  output logic [CNT_W-1:0]    load_total,
  output logic [CNT_W-1:0]    store_total,
  output logic [CNT_W-1:0]    load_miss_total,
  output logic [CNT_W-1:0]    store_miss_total,
  output logic [CNT_W-1:0]    writeback_total
);

  // Set count, way count and block size are powers of two.
  localparam int OFF_W   = $clog2(BLOCK_BYTES);
  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
  localparam int LINES   = NUM_SETS * NUM_WAYS;
  localparam int LINES_W = $clog2(LINES + 1);
  // Row layout, low to high: tags, valid bits, dirty bits, victim pointer.
  localparam int VAL_LSB = NUM_WAYS * TAG_W;
  localparam int DIR_LSB = VAL_LSB + NUM_WAYS;
  localparam int PTR_LSB = DIR_LSB + NUM_WAYS;
  localparam int ROW_W   = PTR_LSB + WAY_W;

  logic [ROW_W-1:0]   mem [NUM_SETS];
  logic [ROW_W-1:0]   rd_row;
  logic [SET_W-1:0]   clr_ptr;
  logic [OP_W-1:0]    req_op;
  logic [SET_W-1:0]   req_set;
  logic [TAG_W-1:0]   req_tag;
  logic [LINES_W-1:0] dirty_count;
  logic [LINES_W-1:0] dirty_count_next;

  logic [NUM_WAYS-1:0]       rd_valid;
  logic [NUM_WAYS-1:0]       rd_dirty;
  logic [WAY_W-1:0]          rd_ptr;
  logic [NUM_WAYS-1:0]       hit_vec;
  logic                      any_hit;
  logic [WAY_W-1:0]          hit_way;
  logic                      dirty_victim;
  logic                      is_store;
  logic                      access;
  logic                      drain;
  logic                      dc_inc;
  logic                      dc_dec;
  logic [ROW_W-1:0]          new_row;
  logic [NUM_WAYS*TAG_W-1:0] new_tags;
  logic [NUM_WAYS-1:0]       new_valid;
  logic [NUM_WAYS-1:0]       new_dirty;
  logic [WAY_W-1:0]          new_ptr;
  logic [RESULT_W-1:0]       lat_next;
  logic                      mem_we;
  logic [SET_W-1:0]          mem_waddr;
  logic [ROW_W-1:0]          mem_wdata;

  assign status.clear_done = (clr_ptr == SET_W'(NUM_SETS - 1));

  assign rd_valid = rd_row[VAL_LSB +: NUM_WAYS];
  assign rd_dirty = rd_row[DIR_LSB +: NUM_WAYS];
  assign rd_ptr   = rd_row[PTR_LSB +: WAY_W];

  assign is_store = (req_op == OP_STORE);
  assign access   = cfg.enable && (req_op inside {OP_LOAD, OP_STORE});
  assign drain    = (req_op == OP_DRAIN);

  always_comb begin
    hit_vec = '0;
    hit_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      hit_vec[w] = rd_valid[w] && (rd_row[w*TAG_W +: TAG_W] == req_tag);
      if (hit_vec[w]) hit_way = WAY_W'(w);
    end
  end

  assign any_hit      = |hit_vec;
  assign dirty_victim = rd_valid[rd_ptr] && rd_dirty[rd_ptr];

  always_comb begin
    new_tags  = rd_row[VAL_LSB-1:0];
    new_valid = rd_valid;
    new_dirty = rd_dirty;
    new_ptr   = rd_ptr;
    if (any_hit) begin
      if (is_store) new_dirty[hit_way] = 1'b1;
    end else begin
      // Fill the way under the pointer, even when another way is empty.
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (WAY_W'(w) == rd_ptr) new_tags[w*TAG_W +: TAG_W] = req_tag;
      end
      new_valid[rd_ptr] = 1'b1;
      new_dirty[rd_ptr] = is_store;
      new_ptr = (rd_ptr == WAY_W'(NUM_WAYS - 1)) ? '0 : rd_ptr + WAY_W'(1);
    end
    new_row = {new_ptr, new_dirty, new_valid, new_tags};
  end

  // Running count of dirty lines, so a drain needs no sweep of the store.
  assign dc_inc = access && is_store && (!any_hit || !rd_dirty[hit_way]);
  assign dc_dec = access && !any_hit && dirty_victim;
  assign dirty_count_next = dirty_count + LINES_W'(dc_inc) - LINES_W'(dc_dec);

  always_comb begin
    lat_next = '0;
    case (req_op)
      OP_LOAD, OP_STORE: begin
        if (!cfg.enable) begin
          lat_next = is_store ? RESULT_W'(cfg.write_lat) : RESULT_W'(cfg.read_lat);
        end else if (any_hit) begin
          lat_next = RESULT_W'(cfg.lookup_lat);
        end else begin
          lat_next = RESULT_W'(cfg.read_lat)
                   + (dirty_victim ? RESULT_W'(cfg.write_lat) : RESULT_W'(0));
        end
      end
      default: lat_next = '0;
    endcase
  end

  assign mem_we    = cmd.clear || (cmd.commit && access);
  assign mem_waddr = cmd.clear ? clr_ptr : req_set;
  assign mem_wdata = cmd.clear ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.capture) rd_row <= mem[address[OFF_W +: SET_W]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op  <= opcode;
      req_set <= address[OFF_W +: SET_W];
      req_tag <= address[ADDR_W-1 -: TAG_W];
    end
    if (cmd.commit) begin
      latency        <= lat_next;
      hit            <= access && any_hit;
      victim_written <= access && !any_hit && dirty_victim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr          <= '0;
      dirty_count      <= '0;
      load_total       <= '0;
      store_total      <= '0;
      load_miss_total  <= '0;
      store_miss_total <= '0;
      writeback_total  <= '0;
    end else begin
      if (cmd.clear) clr_ptr <= clr_ptr + SET_W'(1);
      if (cmd.commit) begin
        dirty_count <= dirty_count_next;
        if (access) begin
          if (is_store) store_total <= store_total + CNT_W'(1);
          else          load_total  <= load_total + CNT_W'(1);
          if (!any_hit) begin
            if (is_store) store_miss_total <= store_miss_total + CNT_W'(1);
            else          load_miss_total  <= load_miss_total + CNT_W'(1);
            if (dirty_victim) writeback_total <= writeback_total + CNT_W'(1);
          end
        end else if (drain) begin
          writeback_total <= writeback_total + CNT_W'(dirty_count);
        end
      end
    end
  end

  a_dirty_bound: assert property (@(posedge clk) disable iff (rst)
    dirty_count <= LINES_W'(LINES))
    else $error("dirty line count exceeds the number of lines");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && access |-> $onehot0(hit_vec))
    else $error("tag matched in more than one way");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> $stable(load_total) || $stable(store_total))
    else $error("load and store counters advanced together");

endmodule

// ----- rtl/set_assoc_writeback_cache_tags.sv -----
`timescale 1ns / 1ps

// Tag store of a set-associative write-back, write-allocate cache with a
// round-robin victim pointer per set and five 32-bit event counters.
// Requests (opcode, address) enter on req_valid/req_ready; each gives one
// response on rsp_valid/rsp_ready carrying latency, hit, victim_written and
// the counter values after that request. Configuration registers are
// written through cfg_write/cfg_index/cfg_data; the user must write them
// only while no request is in flight, as the block does not enforce it.
// A request accepted at one edge is looked up from the registered read of
// its set, and its response is registered when the lookup commits, which
// waits while a held response has not been taken. Another request is
// taken only after that commit; the single-port set memory (read, then
// write back) sets this. A drain takes the same path, using a running
// count of dirty lines. After reset the block clears the set memory one
// set per cycle with req_ready low. If the receiver stalls, the finished
// response is held, a new request may still be taken, and its lookup
// waits until the held response is taken.

module set_assoc_writeback_cache_tags import sawc_pkg::*; #(
  parameter int NUM_SETS    = 8,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [OP_W-1:0]       opcode,
  input  logic [ADDR_W-1:0]     address,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [RESULT_W-1:0]   latency,
  output logic                  hit,
  output logic                  victim_written,
  output logic [CNT_W-1:0]      load_total,
  output logic [CNT_W-1:0]      store_total,
  output logic [CNT_W-1:0]      load_miss_total,
  output logic [CNT_W-1:0]      store_miss_total,
  output logic [CNT_W-1:0]      writeback_total,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sawc_cfg_t    cfg;
  sawc_cmd_t    cmd;
  sawc_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable     <= RST_ENABLE;
      cfg.lookup_lat <= RST_LOOKUP;
      cfg.read_lat   <= RST_READ;
      cfg.write_lat  <= RST_WRITE;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ENABLE: cfg.enable     <= cfg_data[0];
        CFG_LOOKUP: cfg.lookup_lat <= cfg_data[LAT_W-1:0];
        CFG_READ:   cfg.read_lat   <= cfg_data[LAT_W-1:0];
        CFG_WRITE:  cfg.write_lat  <= cfg_data[LAT_W-1:0];
        default:    cfg.enable     <= cfg.enable;
      endcase
    end
  end

  sawc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .status    (status)
  );

  sawc_datapath #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg              (cfg),
    .opcode           (opcode),
    .address          (address),
    .latency          (latency),
    .hit              (hit),
    .victim_written   (victim_written),
    .load_total       (load_total),
    .store_total      (store_total),
    .load_miss_total  (load_miss_total),
    .store_miss_total (store_miss_total),
    .writeback_total  (writeback_total)
  );

endmodule
